FILE: hw/rtl/odo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package odo_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int COUNT_BITS_DEF   = 48;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ENCODER_SPAN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_WRAP           = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_WRAP          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_METERS_PER_TICK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_BASE_WIDTH = 3'd4;

  localparam logic [1:0] OP_LEFT   = 2'd0;
  localparam logic [1:0] OP_RIGHT  = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;

  localparam logic [18:0] SPAN_RESET = 19'd131072;
  localparam logic signed [18:0] LOW_WRAP_RESET  = -19'sd26214;
  localparam logic signed [18:0] HIGH_WRAP_RESET = 19'sd26214;
  localparam logic [31:0] MPT_RESET = 32'd85899346;
  localparam logic [23:0] IBW_RESET = 24'd218453;

  // CORDIC datapath and arithmetic widths
  localparam int XY_W    = 34;
  localparam int MUL_W   = 34;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int TH_W    = 42;
  localparam int VNUM_W  = 61;
  localparam int DEN_W   = 24;
  localparam int ANGLE_W = 32;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [29:0] RAD_TO_ANGLE = 30'd683565276;
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

  typedef enum logic [5:0] {
    S_IDLE, S_L0, S_R0, S_L1, S_R1, S_TH0, S_TH1, S_TH2,
    S_AN0, S_AN1, S_AN2, S_AN3, S_C1, S_C1W,
    S_XL0, S_XL1, S_XL2, S_XL3, S_C0W,
    S_P0, S_P1, S_P2, S_P3, S_P4, S_P5,
    S_V0, S_V1, S_V2, S_V3, S_V4,
    S_D0, S_D0W, S_D1, S_D1W, S_OUT
  } state_t;

  typedef struct packed {
    logic               start;
    logic [ANGLE_W-1:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic            done;
    logic [XY_W-1:0] cos_v;
    logic [XY_W-1:0] sin_v;
  } cordic_rsp_t;

  typedef struct packed {
    logic              start;
    logic [VNUM_W-1:0] num;
    logic [DEN_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [VNUM_W-1:0] quot;
  } div_rsp_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/differential_drive_odometry_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Encoder sample items are taken in idle and never stall the input.
// An update item is dominated by two passes of the iterative CORDIC (skipped when
// the mean distance is zero) and two passes of the one-bit-per-cycle divider;
// the result is held until taken, then the next item.
// Synchronous active-high reset loads the register defaults and clears counts,
// pose and the first-update flag.
module differential_drive_odometry_core #(
  parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF,
  parameter int COUNT_BITS   = odo_pkg::COUNT_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire  [1:0]                          operation,
  input  wire  signed [17:0]                  encoder_value,
  input  wire  [23:0]                         elapsed_time,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic signed [31:0]                  x_position,
  output logic signed [31:0]                  y_position,
  output logic [31:0]                         heading,
  output logic signed [31:0]                  linear_velocity,
  output logic signed [31:0]                  angular_velocity,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire  [odo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [odo_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int MW = odo_pkg::MUL_W;
  localparam int PW = odo_pkg::PROD_W;
  localparam int XW = odo_pkg::XY_W;
  localparam int TW = odo_pkg::TH_W;
  localparam int VW = odo_pkg::VNUM_W;

  odo_pkg::state_t state, state_next;

  logic [18:0]        encoder_span;
  logic signed [18:0] low_wrap;
  logic signed [18:0] high_wrap;
  logic [31:0]        meters_per_tick;
  logic [23:0]        inverse_base_width;

  logic [15:0]            left_wrap_count, right_wrap_count;
  logic signed [17:0]     left_prev_raw, right_prev_raw;
  logic [COUNT_BITS-1:0]  left_unwrapped, right_unwrapped;
  logic [COUNT_BITS-1:0]  left_at_last_update, right_at_last_update;
  logic                   have_previous_update;
  logic [31:0]            pose_x, pose_y, pose_heading;

  logic [23:0]            el;
  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [PW-1:0]   mul_p, acc;
  logic                   neg_l, neg_r;
  logic signed [31:0]     dist_left, dist_right, dist_mean;
  logic signed [TW-1:0]   theta;
  logic [31:0]            angle;
  logic signed [XW-1:0]   cos1, sin1, cos0, sin0, xl, yl;
  logic [VW-1:0]          vnum_lin, vnum_ang;
  logic [31:0]            lin_vel, ang_vel;

  odo_pkg::cordic_req_t cor_req;
  odo_pkg::cordic_rsp_t cor_rsp;
  odo_pkg::div_req_t    div_req;
  odo_pkg::div_rsp_t    div_rsp;

  logic in_accept;
  assign in_accept = in_valid && !in_stall;

  // ---- encoder unwrap ----
  logic                samp_right;
  logic signed [18:0]  enc19, prev19;
  logic [15:0]         count_sel, count_new;
  logic                wrap_up, wrap_dn;
  logic signed [35:0]  wrap_prod;
  logic signed [63:0]  unwrap_sum;

  always_comb begin
    samp_right = operation == odo_pkg::OP_RIGHT;
    enc19      = 19'(encoder_value);
    prev19     = samp_right ? 19'(right_prev_raw) : 19'(left_prev_raw);
    count_sel  = samp_right ? right_wrap_count : left_wrap_count;
    wrap_up    = (enc19 < low_wrap) && (prev19 > high_wrap);
    wrap_dn    = (enc19 > high_wrap) && (prev19 < low_wrap);
    count_new  = count_sel + 16'(wrap_up) - 16'(wrap_dn);
    wrap_prod  = 36'($signed(count_new)) * 36'($signed({1'b0, encoder_span}));
    unwrap_sum = 64'(encoder_value) + 64'(wrap_prod);
  end

  // ---- wheel distance helpers ----
  function automatic logic [32:0] clamp_mag(input logic [COUNT_BITS-1:0] diff);
    logic [COUNT_BITS-1:0] mag;
    logic [63:0]           magx;
    mag  = diff[COUNT_BITS-1] ? (~diff + 1'b1) : diff;
    magx = 64'(mag);
    return (magx > 64'h1_0000_0000) ? 33'h1_0000_0000 : magx[32:0];
  endfunction

  function automatic logic signed [31:0] dist_of(input logic neg,
                                                input logic signed [PW-1:0] p);
    logic [64:0] rsum;
    logic [48:0] r;
    logic [30:0] rc;
    rsum = p[64:0] + 65'h8000;
    r    = rsum[64:16];
    rc   = (r > 49'h7FFF_FFFF) ? 31'h7FFF_FFFF : r[30:0];
    return neg ? -$signed({1'b0, rc}) : $signed({1'b0, rc});
  endfunction

  function automatic logic [31:0] sat_of(input logic neg, input logic [VW-1:0] q);
    logic [31:0] v;
    if (neg) begin
      v = (q > VW'(33'h0_8000_0000)) ? 32'h8000_0000 : -q[31:0];
    end else begin
      v = (q > VW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
    end
    return v;
  endfunction

  logic [COUNT_BITS-1:0]  diff_l, diff_r;
  logic signed [33:0]     th_diff;
  logic signed [32:0]     mean_sum, mean_adj;
  logic signed [PW-1:0]   th_sum;
  logic signed [47:0]     th48;
  logic [47:0]            ang48;
  logic [PW-1:0]          px_sum, py_sum;
  logic [32:0]            abs_d;
  logic [TW-1:0]          abs_th;

  always_comb begin
    diff_l   = left_unwrapped - left_at_last_update;
    diff_r   = right_unwrapped - right_at_last_update;
    th_diff  = 34'(dist_right) - 34'(dist_left);
    mean_sum = 33'(dist_right) + 33'(dist_left);
    // truncate toward zero
    mean_adj = mean_sum + $signed({32'b0, mean_sum[32]});
    th_sum   = mul_p + PW'(32768);
    th48     = 48'(theta);
    ang48    = acc[47:0] + {mul_p[23:0], 24'b0} + 48'h8000;
    px_sum   = acc - mul_p;
    py_sum   = acc + mul_p;
    abs_d    = dist_mean[31] ? -33'(dist_mean) : 33'(dist_mean);
    abs_th   = theta[TW-1] ? -theta : theta;
  end

  // ---- next state ----
  always_comb begin
    state_next = state;
    case (state)
      odo_pkg::S_IDLE: begin
        if (in_accept && operation == odo_pkg::OP_UPDATE) state_next = odo_pkg::S_L0;
      end
      odo_pkg::S_L0:  state_next = odo_pkg::S_R0;
      odo_pkg::S_R0:  state_next = odo_pkg::S_L1;
      odo_pkg::S_L1:  state_next = odo_pkg::S_R1;
      odo_pkg::S_R1:  state_next = odo_pkg::S_TH0;
      odo_pkg::S_TH0: state_next = odo_pkg::S_TH1;
      odo_pkg::S_TH1: state_next = odo_pkg::S_TH2;
      odo_pkg::S_TH2: state_next = odo_pkg::S_AN0;
      odo_pkg::S_AN0: state_next = odo_pkg::S_AN1;
      odo_pkg::S_AN1: state_next = odo_pkg::S_AN2;
      odo_pkg::S_AN2: state_next = odo_pkg::S_AN3;
      odo_pkg::S_AN3: state_next = odo_pkg::S_C1;
      odo_pkg::S_C1:  state_next = (dist_mean != 0) ? odo_pkg::S_C1W : odo_pkg::S_V0;
      odo_pkg::S_C1W: if (cor_rsp.done) state_next = odo_pkg::S_XL0;
      odo_pkg::S_XL0: state_next = odo_pkg::S_XL1;
      odo_pkg::S_XL1: state_next = odo_pkg::S_XL2;
      odo_pkg::S_XL2: state_next = odo_pkg::S_XL3;
      odo_pkg::S_XL3: state_next = odo_pkg::S_C0W;
      odo_pkg::S_C0W: if (cor_rsp.done) state_next = odo_pkg::S_P0;
      odo_pkg::S_P0:  state_next = odo_pkg::S_P1;
      odo_pkg::S_P1:  state_next = odo_pkg::S_P2;
      odo_pkg::S_P2:  state_next = odo_pkg::S_P3;
      odo_pkg::S_P3:  state_next = odo_pkg::S_P4;
      odo_pkg::S_P4:  state_next = odo_pkg::S_P5;
      odo_pkg::S_P5:  state_next = odo_pkg::S_V0;
      odo_pkg::S_V0:  state_next = odo_pkg::S_V1;
      odo_pkg::S_V1:  state_next = odo_pkg::S_V2;
      odo_pkg::S_V2:  state_next = odo_pkg::S_V3;
      odo_pkg::S_V3:  state_next = odo_pkg::S_V4;
      odo_pkg::S_V4:  state_next = odo_pkg::S_D0;
      odo_pkg::S_D0:  state_next = odo_pkg::S_D0W;
      odo_pkg::S_D0W: if (div_rsp.done) state_next = odo_pkg::S_D1;
      odo_pkg::S_D1:  state_next = odo_pkg::S_D1W;
      odo_pkg::S_D1W: if (div_rsp.done) state_next = odo_pkg::S_OUT;
      odo_pkg::S_OUT: if (!out_stall) state_next = odo_pkg::S_IDLE;
      default:        state_next = odo_pkg::S_IDLE;
    endcase
  end

  // ---- control outputs ----
  always_comb begin
    in_stall      = state != odo_pkg::S_IDLE;
    cfg_ready     = state == odo_pkg::S_IDLE;
    out_valid     = state == odo_pkg::S_OUT;
    cor_req.start = (state == odo_pkg::S_C1 && dist_mean != 0) || state == odo_pkg::S_XL2;
    cor_req.angle = (state == odo_pkg::S_XL2) ? pose_heading : angle;
    div_req.start = state == odo_pkg::S_D0 || state == odo_pkg::S_D1;
    div_req.num   = (state == odo_pkg::S_D1) ? vnum_ang : vnum_lin;
    div_req.den   = (el == 24'd0) ? 24'd1 : el;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= odo_pkg::S_IDLE;
    else     state <= state_next;
  end

  // ---- configuration and persistent state ----
  always_ff @(posedge clk) begin
    if (rst) begin
      encoder_span         <= odo_pkg::SPAN_RESET;
      low_wrap             <= odo_pkg::LOW_WRAP_RESET;
      high_wrap            <= odo_pkg::HIGH_WRAP_RESET;
      meters_per_tick      <= odo_pkg::MPT_RESET;
      inverse_base_width   <= odo_pkg::IBW_RESET;
      left_wrap_count      <= '0;
      right_wrap_count     <= '0;
      left_prev_raw        <= '0;
      right_prev_raw       <= '0;
      left_unwrapped       <= '0;
      right_unwrapped      <= '0;
      left_at_last_update  <= '0;
      right_at_last_update <= '0;
      have_previous_update <= 1'b0;
      pose_x               <= '0;
      pose_y               <= '0;
      pose_heading         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          odo_pkg::CFG_ENCODER_SPAN:       encoder_span       <= cfg_data[18:0];
          odo_pkg::CFG_LOW_WRAP:           low_wrap           <= cfg_data[18:0];
          odo_pkg::CFG_HIGH_WRAP:          high_wrap          <= cfg_data[18:0];
          odo_pkg::CFG_METERS_PER_TICK:    meters_per_tick    <= cfg_data;
          odo_pkg::CFG_INVERSE_BASE_WIDTH: inverse_base_width <= cfg_data[23:0];
          default: ;
        endcase
      end
      if (in_accept && operation == odo_pkg::OP_LEFT) begin
        left_wrap_count <= count_new;
        left_prev_raw   <= encoder_value;
        left_unwrapped  <= unwrap_sum[COUNT_BITS-1:0];
      end
      if (in_accept && operation == odo_pkg::OP_RIGHT) begin
        right_wrap_count <= count_new;
        right_prev_raw   <= encoder_value;
        right_unwrapped  <= unwrap_sum[COUNT_BITS-1:0];
      end
      if (state == odo_pkg::S_R0) begin
        left_at_last_update  <= left_unwrapped;
        right_at_last_update <= right_unwrapped;
        have_previous_update <= 1'b1;
      end
      if (state == odo_pkg::S_P3) pose_x <= pose_x + px_sum[61:30];
      if (state == odo_pkg::S_P5) pose_y <= pose_y + py_sum[61:30];
      if (state == odo_pkg::S_V0) pose_heading <= pose_heading + angle;
    end
  end

  // ---- shared multiplier ----
  always_ff @(posedge clk) begin
    mul_p <= PW'(mul_a) * PW'(mul_b);
  end

  // ---- update datapath ----
  always_ff @(posedge clk) begin
    if (in_accept) el <= elapsed_time;
    case (state)
      odo_pkg::S_L0: begin
        mul_a <= have_previous_update ? $signed({1'b0, clamp_mag(diff_l)}) : '0;
        mul_b <= $signed({2'b00, meters_per_tick});
        neg_l <= diff_l[COUNT_BITS-1];
      end
      odo_pkg::S_R0: begin
        mul_a <= have_previous_update ? $signed({1'b0, clamp_mag(diff_r)}) : '0;
        neg_r <= diff_r[COUNT_BITS-1];
      end
      odo_pkg::S_L1: dist_left  <= dist_of(neg_l, mul_p);
      odo_pkg::S_R1: dist_right <= dist_of(neg_r, mul_p);
      odo_pkg::S_TH0: begin
        mul_a     <= th_diff;
        mul_b     <= $signed({10'b0, inverse_base_width});
        dist_mean <= mean_adj[32:1];
      end
      odo_pkg::S_TH2: theta <= th_sum[TW+15:16];
      odo_pkg::S_AN0: begin
        mul_a <= $signed({10'b0, th48[23:0]});
        mul_b <= $signed({4'b0, odo_pkg::RAD_TO_ANGLE});
      end
      odo_pkg::S_AN1: mul_a <= $signed({10'b0, th48[47:24]});
      odo_pkg::S_AN2: acc <= mul_p;
      odo_pkg::S_AN3: angle <= ang48[47:16];
      odo_pkg::S_C1W: begin
        if (cor_rsp.done) begin
          cos1 <= $signed(cor_rsp.cos_v);
          sin1 <= $signed(cor_rsp.sin_v);
        end
      end
      odo_pkg::S_XL0: begin
        mul_a <= cos1;
        mul_b <= MW'(dist_mean);
      end
      odo_pkg::S_XL1: mul_a <= sin1;
      odo_pkg::S_XL2: xl <= mul_p[XW+29:30];
      odo_pkg::S_XL3: yl <= -$signed(mul_p[XW+29:30]);
      odo_pkg::S_C0W: begin
        if (cor_rsp.done) begin
          cos0 <= $signed(cor_rsp.cos_v);
          sin0 <= $signed(cor_rsp.sin_v);
        end
      end
      odo_pkg::S_P0: begin
        mul_a <= cos0;
        mul_b <= xl;
      end
      odo_pkg::S_P1: begin
        mul_a <= sin0;
        mul_b <= yl;
      end
      odo_pkg::S_P2: begin
        acc   <= mul_p;
        mul_a <= sin0;
        mul_b <= xl;
      end
      odo_pkg::S_P3: begin
        mul_a <= cos0;
        mul_b <= yl;
      end
      odo_pkg::S_P4: acc <= mul_p;
      odo_pkg::S_V0: begin
        mul_a <= $signed({1'b0, abs_d});
        mul_b <= $signed({14'b0, odo_pkg::USEC_PER_SEC});
      end
      odo_pkg::S_V1: mul_a <= $signed({13'b0, abs_th[20:0]});
      odo_pkg::S_V2: begin
        vnum_lin <= mul_p[VW-1:0];
        mul_a    <= $signed({14'b0, abs_th[40:21]});
      end
      odo_pkg::S_V3: acc <= mul_p;
      odo_pkg::S_V4: vnum_ang <= acc[VW-1:0] + {mul_p[VW-22:0], 21'b0};
      odo_pkg::S_D0W: if (div_rsp.done) lin_vel <= sat_of(dist_mean[31], div_rsp.quot);
      odo_pkg::S_D1W: if (div_rsp.done) ang_vel <= sat_of(theta[TW-1], div_rsp.quot);
      default: ;
    endcase
  end

  odo_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk(clk),
    .rst(rst),
    .req(cor_req),
    .rsp(cor_rsp)
  );

  odo_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  assign x_position       = pose_x;
  assign y_position       = pose_y;
  assign heading          = pose_heading;
  assign linear_velocity  = lin_vel;
  assign angular_velocity = ang_vel;

  a_busy_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("result pending while input is open");

  a_update_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && operation == odo_pkg::OP_UPDATE |=> in_stall)
    else $error("update item did not start the sequencer");

  a_prev_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(have_previous_update) |-> have_previous_update)
    else $error("first-update flag dropped");

  a_cordic_done_waited: assert property (@(posedge clk) disable iff (rst)
    cor_rsp.done |-> (state == odo_pkg::S_C1W || state == odo_pkg::S_C0W))
    else $error("cordic finished outside a wait state");

endmodule
`default_nettype wire

FILE: hw/rtl/odo_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module odo_cordic #(
  parameter int CORDIC_STEPS = odo_pkg::CORDIC_STEPS_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  odo_pkg::cordic_req_t req,
  output odo_pkg::cordic_rsp_t rsp
);

  localparam int CNT_W = $clog2(CORDIC_STEPS + 1);

  logic                           busy;
  logic                           done;
  logic [CNT_W-1:0]               step;
  logic                           flip;
  logic signed [odo_pkg::XY_W-1:0] x;
  logic signed [odo_pkg::XY_W-1:0] y;
  logic signed [odo_pkg::XY_W-1:0] z;

  logic [1:0]                      quad;
  logic                            start_flip;
  logic [31:0]                     folded;
  logic signed [odo_pkg::XY_W-1:0] x_sh;
  logic signed [odo_pkg::XY_W-1:0] y_sh;
  logic signed [odo_pkg::XY_W-1:0] at;

  always_comb begin
    quad       = req.angle[31:30];
    start_flip = (quad == 2'd1) || (quad == 2'd2);
    // fold the left half plane onto the right one
    folded     = {req.angle[31] ^ start_flip, req.angle[30:0]};
    x_sh       = x >>> step;
    y_sh       = y >>> step;
    at         = $signed({2'b00, odo_pkg::atan_entry(5'(step))});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == CNT_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x    <= odo_pkg::CORDIC_GAIN;
      y    <= '0;
      z    <= odo_pkg::XY_W'($signed(folded));
      flip <= start_flip;
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - y_sh;
        y <= y + x_sh;
        z <= z - at;
      end else begin
        x <= x + y_sh;
        y <= y - x_sh;
        z <= z + at;
      end
    end
  end

  always_comb begin
    rsp.done  = done;
    rsp.cos_v = flip ? -x : x;
    rsp.sin_v = flip ? -y : y;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/odo_div.sv
`timescale 1ns / 1ps
`default_nettype none
module odo_div (
  input  wire               clk,
  input  wire               rst,
  input  odo_pkg::div_req_t req,
  output odo_pkg::div_rsp_t rsp
);

  localparam int NW    = odo_pkg::VNUM_W;
  localparam int DW    = odo_pkg::DEN_W;
  localparam int CNT_W = $clog2(NW + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [NW-1:0]    num_sh;
  logic [DW:0]      rem;
  logic [DW-1:0]    den;

  logic [DW:0]      rem_sh;
  logic             ge;

  always_comb begin
    rem_sh = {rem[DW-1:0], num_sh[NW-1]};
    ge     = rem_sh >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      num_sh <= req.num;
      rem    <= '0;
      den    <= req.den;
    end else if (busy) begin
      rem    <= ge ? (rem_sh - {1'b0, den}) : rem_sh;
      num_sh <= {num_sh[NW-2:0], ge};
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.quot = num_sh;
  end

endmodule
`default_nettype wire
